// File: hw/rtl/ept_pkg.sv
// Shared types and constants of the echo probe tracker.
`default_nettype none
package ept_pkg;

    localparam int CNT_W     = 32;
    localparam int SUM_W     = 64;
    localparam int SEQ_W     = 16;
    localparam int PCT_W     = 7;
    localparam int CFG_IDX_W = 2;

    localparam logic [1:0] KIND_SEND  = 2'd0;
    localparam logic [1:0] KIND_REPLY = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;
    localparam logic [1:0] KIND_CLOSE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_OUR_IDENT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOSTS_IN_USE = 2'd1;

    localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

    typedef struct packed {
        logic [1:0]       kind;
        logic [3:0]       host;
        logic [SEQ_W-1:0] echo_id;
        logic [SEQ_W-1:0] seq;
        logic [CNT_W-1:0] rtt_us;
        logic             runt;
    } t_in;

    typedef struct packed {
        logic [SEQ_W-1:0] assigned_seq;
        logic             accepted;
        logic             duplicate;
        logic [CNT_W-1:0] total_sent;
        logic [CNT_W-1:0] total_recv;
        logic [CNT_W-1:0] total_dups;
        logic [PCT_W-1:0] percent_received;
        logic             percent_valid;
        logic [CNT_W-1:0] avg_trip_us;
        logic             trip_valid;
        logic             timed_out;
        logic             error_seen;
    } t_out;

    // one row of the per-host table
    typedef struct packed {
        logic [CNT_W-1:0] sent_total;
        logic [CNT_W-1:0] recv_total;
        logic [CNT_W-1:0] dup_total;
        logic [CNT_W-1:0] p_sent;
        logic [CNT_W-1:0] p_recv;
        logic [CNT_W-1:0] p_dup;
        logic [SUM_W-1:0] p_trip;
        logic             p_err;
    } t_host_rec;

    localparam int REC_W = $bits(t_host_rec);

endpackage
`default_nettype wire

// File: hw/rtl/ept_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ept_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// File: hw/rtl/ept_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module ept_div #(
    parameter int DW = 64,
    parameter int VW = 33
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [DW-1:0] i_dividend,
    input  wire logic [VW-1:0] i_divisor,
    output logic               o_done,
    output logic      [DW-1:0] o_quotient
);

    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] r_quo;
    logic [VW-1:0] r_rem;
    logic [VW-1:0] r_dvs;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [VW:0]   trial;
    logic          fits;

    assign trial = {r_rem, r_quo[DW-1]};
    assign fits  = trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DW-2:0], fits};
            r_rem <= fits ? VW'(trial - {1'b0, r_dvs}) : trial[VW-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule
`default_nettype wire

// File: hw/rtl/echo_probe_tracker.sv
// Echo probe tracker top level: per-host counters and duplicate map.
// Each item is read in S_READ and written back in S_EXEC; send, reply and error results
// are then posted. A period close first runs the shared serial divider for the percentage,
// then for the average trip, each only when valid. One item at a time.
// Reset: a clearing pass over max(HOST_SLOTS, DUP_WINDOW) addresses zeroes both tables;
// no item is accepted during it, configuration writes are.
`default_nettype none
module echo_probe_tracker #(
    parameter int HOST_SLOTS = 16,
    parameter int DUP_WINDOW = 1024
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire ept_pkg::t_in                    i_in,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output ept_pkg::t_out                        o_out,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [ept_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [ept_pkg::SEQ_W-1:0]       i_cfg_data
);

    localparam int HAW       = (HOST_SLOTS > 1) ? $clog2(HOST_SLOTS) : 1;
    localparam int HXW       = (HAW > 4) ? HAW : 4;
    localparam int SAW       = $clog2(DUP_WINDOW);
    localparam int CLR_DEPTH = (HOST_SLOTS > DUP_WINDOW) ? HOST_SLOTS : DUP_WINDOW;
    localparam int CLW       = $clog2(CLR_DEPTH);
    localparam int DVW       = ept_pkg::CNT_W + 1;
    localparam int PRW       = ept_pkg::CNT_W + ept_pkg::PCT_W;

    typedef enum logic [7:0] {
        S_CLEAR    = 8'b0000_0001,
        S_IDLE     = 8'b0000_0010,
        S_READ     = 8'b0000_0100,
        S_EXEC     = 8'b0000_1000,
        S_PCT_GO   = 8'b0001_0000,
        S_PCT_WAIT = 8'b0010_0000,
        S_AVG_GO   = 8'b0100_0000,
        S_AVG_WAIT = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic                          r_out_pend;  // result ready to post
    logic [ept_pkg::SEQ_W-1:0]     r_our_ident;
    logic [4:0]                    r_hosts;
    logic [ept_pkg::SEQ_W-1:0]     r_next_seq, n_next_seq;
    logic [CLW-1:0]                r_clr_cnt;
    logic                          r_out_valid;
    ept_pkg::t_out                 r_out;
    ept_pkg::t_in                  r_item;
    ept_pkg::t_out                 r_res, n_res;
    logic [ept_pkg::SUM_W-1:0]     r_dvd_pct;
    logic [ept_pkg::CNT_W-1:0]     r_ps;
    logic [DVW-1:0]                r_cnt;
    logic [ept_pkg::SUM_W-1:0]     r_sum;

    ept_pkg::t_host_rec            rec, n_rec;
    logic [ept_pkg::REC_W-1:0]     host_rdata;
    logic [ept_pkg::REC_W-1:0]     host_wdata;
    logic [HAW-1:0]                host_addr, host_waddr;
    logic                          host_we;
    logic [0:0]                    seen_rdata;
    logic [0:0]                    seen_wdata;
    logic [SAW-1:0]                seen_raddr, seen_waddr;
    logic                          seen_we;
    logic [HXW-1:0]                host_x;
    logic                          host_ok, id_ok;
    logic                          upd_host, upd_seen, upd_bit;
    logic [SAW-1:0]                upd_slot;
    logic                          div_start, div_done;
    logic [ept_pkg::SUM_W-1:0]     div_dvd, div_q;
    logic [DVW-1:0]                div_dvs;
    logic                          out_free;
    logic [PRW-1:0]                pct_prod;

    assign host_x     = HXW'(r_item.host);
    assign host_addr  = host_x[HAW-1:0];
    assign host_ok    = ({1'b0, r_item.host} < r_hosts) && (32'(r_item.host) < HOST_SLOTS);
    assign id_ok      = host_ok && !r_item.runt && (r_item.echo_id == r_our_ident);
    assign seen_raddr = SAW'(r_item.seq % DUP_WINDOW);
    assign rec        = ept_pkg::t_host_rec'(host_rdata);
    assign out_free   = !r_out_valid || i_out_ready;
    assign pct_prod   = PRW'(rec.p_recv) * PRW'(ept_pkg::PCT_FULL);

    // read-modify-write of the host row and the seen bit
    always_comb begin
        n_rec      = rec;
        n_res      = '0;
        n_next_seq = r_next_seq;
        upd_host   = 1'b0;
        upd_seen   = 1'b0;
        upd_bit    = 1'b0;
        upd_slot   = seen_raddr;
        if (host_ok) begin
            upd_host = 1'b1;
            case (r_item.kind)
                ept_pkg::KIND_SEND: begin
                    n_res.assigned_seq = r_next_seq;
                    upd_seen           = 1'b1;
                    upd_slot           = SAW'(r_next_seq % DUP_WINDOW);
                    n_next_seq         = r_next_seq + 1'b1;
                    n_rec.sent_total   = rec.sent_total + 1'b1;
                    n_rec.p_sent       = rec.p_sent + 1'b1;
                end
                ept_pkg::KIND_REPLY: begin
                    if (id_ok) begin
                        n_res.accepted = 1'b1;
                        n_rec.p_trip   = rec.p_trip + ept_pkg::SUM_W'(r_item.rtt_us);
                        if (seen_rdata[0]) begin
                            n_res.duplicate = 1'b1;
                            n_rec.dup_total = rec.dup_total + 1'b1;
                            n_rec.p_dup     = rec.p_dup + 1'b1;
                        end else begin
                            upd_seen         = 1'b1;
                            upd_bit          = 1'b1;
                            n_rec.recv_total = rec.recv_total + 1'b1;
                            n_rec.p_recv     = rec.p_recv + 1'b1;
                        end
                    end
                end
                ept_pkg::KIND_ERROR: begin
                    if (id_ok) begin
                        n_res.accepted = 1'b1;
                        n_rec.p_err    = 1'b1;
                    end
                end
                default: begin
                    n_res.percent_valid = rec.p_sent != '0;
                    n_res.trip_valid    = rec.p_recv != '0;
                    n_res.timed_out     = (rec.p_sent != '0) && (rec.p_recv == '0) && !rec.p_err;
                    n_res.error_seen    = rec.p_err;
                    n_rec.p_sent        = '0;
                    n_rec.p_recv        = '0;
                    n_rec.p_dup         = '0;
                    n_rec.p_trip        = '0;
                    n_rec.p_err         = 1'b0;
                end
            endcase
            n_res.total_sent = n_rec.sent_total;
            n_res.total_recv = n_rec.recv_total;
            n_res.total_dups = n_rec.dup_total;
        end
    end

    // memory write ports: clearing pass or write-back
    always_comb begin
        host_we    = 1'b0;
        host_waddr = host_addr;
        host_wdata = n_rec;
        seen_we    = 1'b0;
        seen_waddr = upd_slot;
        seen_wdata = upd_bit;
        if (r_state == S_CLEAR) begin
            host_we    = 32'(r_clr_cnt) < HOST_SLOTS;
            host_waddr = HAW'(r_clr_cnt);
            host_wdata = '0;
            seen_we    = 32'(r_clr_cnt) < DUP_WINDOW;
            seen_waddr = SAW'(r_clr_cnt);
            seen_wdata = 1'b0;
        end else if (r_state == S_EXEC) begin
            host_we = upd_host;
            seen_we = upd_seen;
        end
    end

    always_comb begin
        div_start = 1'b0;
        div_dvd   = r_sum;
        div_dvs   = r_cnt;
        if (r_state == S_PCT_GO) begin
            div_start = 1'b1;
            div_dvd   = r_dvd_pct;
            div_dvs   = DVW'(r_ps);
        end else if (r_state == S_AVG_GO) begin
            div_start = 1'b1;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR:    if (r_clr_cnt == CLW'(CLR_DEPTH - 1)) n_state = S_IDLE;
            S_IDLE:     if (i_in_valid && !r_out_pend) n_state = S_READ;
            S_READ:     n_state = S_EXEC;
            S_EXEC: begin
                if (n_res.percent_valid) begin
                    n_state = S_PCT_GO;
                end else if (n_res.trip_valid) begin
                    n_state = S_AVG_GO;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_PCT_GO:   n_state = S_PCT_WAIT;
            S_PCT_WAIT: if (div_done) n_state = r_res.trip_valid ? S_AVG_GO : S_IDLE;
            S_AVG_GO:   n_state = S_AVG_WAIT;
            S_AVG_WAIT: if (div_done) n_state = S_IDLE;
            default:    n_state = S_CLEAR;
        endcase
    end

    logic n_done_item;
    assign n_done_item = ((r_state == S_EXEC) && (n_state == S_IDLE))
                      || ((r_state == S_PCT_WAIT) && (n_state == S_IDLE))
                      || ((r_state == S_AVG_WAIT) && div_done);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_cnt   <= '0;
            r_next_seq  <= '0;
            r_our_ident <= '0;
            r_hosts     <= '0;
            r_out_valid <= 1'b0;
            r_out_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
            if (r_state == S_EXEC) begin
                r_next_seq <= n_next_seq;
            end
            if (i_cfg_valid) begin
                if (i_cfg_index == ept_pkg::CFG_OUR_IDENT) begin
                    r_our_ident <= i_cfg_data;
                end else if (i_cfg_index == ept_pkg::CFG_HOSTS_IN_USE) begin
                    r_hosts <= i_cfg_data[4:0];
                end
            end
            // post the held result as soon as the output register frees
            if (r_out_pend && out_free) begin
                r_out_valid <= 1'b1;
                r_out_pend  <= 1'b0;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (n_done_item) begin
                r_out_pend <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid && !r_out_pend) begin
            r_item <= i_in;
        end
        if (r_state == S_EXEC) begin
            r_res     <= n_res;
            r_dvd_pct <= ept_pkg::SUM_W'(pct_prod);
            r_ps      <= rec.p_sent;
            r_cnt     <= DVW'(rec.p_recv) + DVW'(rec.p_dup);
            r_sum     <= rec.p_trip;
        end
        if (r_state == S_PCT_WAIT && div_done) begin
            r_res.percent_received <= (div_q > ept_pkg::SUM_W'(ept_pkg::PCT_FULL))
                                    ? ept_pkg::PCT_FULL : div_q[ept_pkg::PCT_W-1:0];
        end
        if (r_state == S_AVG_WAIT && div_done) begin
            r_res.avg_trip_us <= (div_q[ept_pkg::SUM_W-1:ept_pkg::CNT_W] != '0)
                               ? '1 : div_q[ept_pkg::CNT_W-1:0];
        end
        if (r_out_pend && out_free) begin
            r_out <= r_res;
        end
    end

    ept_ram #(
        .WIDTH(ept_pkg::REC_W),
        .DEPTH(HOST_SLOTS)
    ) u_host_ram (
        .i_clk  (i_clk),
        .i_we   (host_we),
        .i_waddr(host_waddr),
        .i_wdata(host_wdata),
        .i_raddr(host_addr),
        .o_rdata(host_rdata)
    );

    ept_ram #(
        .WIDTH(1),
        .DEPTH(DUP_WINDOW)
    ) u_seen_ram (
        .i_clk  (i_clk),
        .i_we   (seen_we),
        .i_waddr(seen_waddr),
        .i_wdata(seen_wdata),
        .i_raddr(seen_raddr),
        .o_rdata(seen_rdata)
    );

    ept_div #(
        .DW(ept_pkg::SUM_W),
        .VW(DVW)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_dividend(div_dvd),
        .i_divisor (div_dvs),
        .o_done    (div_done),
        .o_quotient(div_q)
    );

    assign o_in_ready  = (r_state == S_IDLE) && !r_out_pend;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

`ifndef SYNTHESIS
    a_accept_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_READ))
        else $error("accepted item did not start a table read");
    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_PCT_WAIT || r_state == S_AVG_WAIT))
        else $error("divider finished outside a wait state");
    a_host_we_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        host_we |-> (r_state == S_CLEAR || r_state == S_EXEC))
        else $error("host table written outside clear or execute");
    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.percent_received <= ept_pkg::PCT_FULL))
        else $error("percentage above full scale");
`endif

endmodule
`default_nettype wire

// File: dv/echo_probe_tracker_test.sv
// Testbench for the echo probe tracker: random and directed items checked against a predictor.
`default_nettype none
module echo_probe_tracker_test;
    timeunit 1ns;
    timeprecision 1ps;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic o_in_ready;
    ept_pkg::t_in in_item = '0;
    logic o_out_valid;
    logic out_ready = 1'b0;
    ept_pkg::t_out o_out;
    logic cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [ept_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [ept_pkg::SEQ_W-1:0] cfg_data = '0;

    echo_probe_tracker u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(o_in_ready), .i_in(in_item),
        .o_out_valid(o_out_valid), .i_out_ready(out_ready), .o_out(o_out),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // tracker state as the predictor sees it
    logic [15:0] ident_m = '0;
    logic [4:0] hosts_m = '0;
    logic [15:0] seq_m = '0;
    bit seen_m [1024];
    logic [31:0] sent_tot [16], recv_tot [16], dup_tot [16];
    logic [31:0] p_sent [16], p_recv [16], p_dup [16];
    logic [63:0] p_trip [16];
    bit p_err [16];

    ept_pkg::t_in pending_items [$];
    ept_pkg::t_out expected_results [$];
    int errors = 0;
    int hold_reqs = 0;
    int hold_done = 0;

    task automatic track_item(input ept_pkg::t_in it);
        ept_pkg::t_out r;
        bit ok;
        bit hit;
        logic [63:0] pct;
        logic [63:0] avg;
        int h;
        r = '0;
        h = it.host;
        ok = it.host < hosts_m;
        hit = ok && !it.runt && it.echo_id == ident_m;
        if (ok) begin
            case (it.kind)
                ept_pkg::KIND_SEND: begin
                    r.assigned_seq = seq_m;
                    seen_m[seq_m % 1024] = 1'b0;
                    seq_m = seq_m + 16'd1;
                    sent_tot[h]++;
                    p_sent[h]++;
                end
                ept_pkg::KIND_REPLY: begin
                    if (hit) begin
                        r.accepted = 1'b1;
                        p_trip[h] += 64'(it.rtt_us);
                        if (seen_m[it.seq % 1024]) begin
                            r.duplicate = 1'b1;
                            dup_tot[h]++;
                            p_dup[h]++;
                        end else begin
                            seen_m[it.seq % 1024] = 1'b1;
                            recv_tot[h]++;
                            p_recv[h]++;
                        end
                    end
                end
                ept_pkg::KIND_ERROR: begin
                    if (hit) begin
                        r.accepted = 1'b1;
                        p_err[h] = 1'b1;
                    end
                end
                default: begin
                    if (p_sent[h] > 0) begin
                        pct = (64'(p_recv[h]) * 64'd100) / 64'(p_sent[h]);
                        r.percent_received = (pct > 64'd100) ? ept_pkg::PCT_FULL
                                                             : ept_pkg::PCT_W'(pct);
                        r.percent_valid = 1'b1;
                    end
                    if (p_recv[h] > 0) begin
                        avg = p_trip[h] / (64'(p_recv[h]) + 64'(p_dup[h]));
                        r.avg_trip_us = (avg > 64'hFFFF_FFFF) ? '1 : avg[31:0];
                        r.trip_valid = 1'b1;
                    end
                    r.timed_out = p_sent[h] > 0 && p_recv[h] == 0 && !p_err[h];
                    r.error_seen = p_err[h];
                    p_sent[h] = '0;
                    p_recv[h] = '0;
                    p_dup[h] = '0;
                    p_trip[h] = '0;
                    p_err[h] = 1'b0;
                end
            endcase
            r.total_sent = sent_tot[h];
            r.total_recv = recv_tot[h];
            r.total_dups = dup_tot[h];
        end
        expected_results.push_back(r);
    endtask

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    // driver
    int tx_gap = 0;
    bit tx_burst = 1'b0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || o_in_ready) begin
            if (in_valid) track_item(in_item);
            if ($urandom_range(0, 15) == 0) tx_burst = ~tx_burst;
            if (tx_gap > 0) begin
                tx_gap <= tx_gap - 1;
                in_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                in_item <= pending_items.pop_front();
                in_valid <= 1'b1;
                tx_gap <= tx_burst ? 0 : $urandom_range(0, 5);
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // monitor
    int rx_wait = 0;
    int hold_cnt = 0;
    bit rx_burst = 1'b0;
    always @(posedge i_clk) begin
        ept_pkg::t_out e;
        int w;
        if (o_out_valid && out_ready && i_rst_n) begin
            if (expected_results.size() == 0) begin
                $display("%0t: result with none expected: expected none, actual %h",
                         $time, o_out);
                errors++;
            end else begin
                e = expected_results.pop_front();
                check_field("assigned_seq", e.assigned_seq, o_out.assigned_seq);
                check_field("accepted", e.accepted, o_out.accepted);
                check_field("duplicate", e.duplicate, o_out.duplicate);
                check_field("total_sent", e.total_sent, o_out.total_sent);
                check_field("total_recv", e.total_recv, o_out.total_recv);
                check_field("total_dups", e.total_dups, o_out.total_dups);
                check_field("percent_received", e.percent_received, o_out.percent_received);
                check_field("percent_valid", e.percent_valid, o_out.percent_valid);
                check_field("avg_trip_us", e.avg_trip_us, o_out.avg_trip_us);
                check_field("trip_valid", e.trip_valid, o_out.trip_valid);
                check_field("timed_out", e.timed_out, o_out.timed_out);
                check_field("error_seen", e.error_seen, o_out.error_seen);
            end
        end
        if ($urandom_range(0, 15) == 0) rx_burst = ~rx_burst;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_reqs != hold_done) begin
            hold_done <= hold_reqs;
            hold_cnt <= 400;
            out_ready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            out_ready <= (hold_cnt == 1);
        end else if (o_out_valid && out_ready) begin
            w = rx_burst ? 0 : $urandom_range(0, 5);
            rx_wait <= w;
            out_ready <= (w == 0);
        end else if (rx_wait > 0) begin
            rx_wait <= rx_wait - 1;
            out_ready <= (rx_wait == 1);
        end else begin
            out_ready <= 1'b1;
        end
    end

    task automatic write_reg(input logic [ept_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] val);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge i_clk); while (!(cfg_valid && o_cfg_ready));
        if (idx == ept_pkg::CFG_OUR_IDENT) ident_m = val;
        else if (idx == ept_pkg::CFG_HOSTS_IN_USE) hosts_m = val[4:0];
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        do @(negedge i_clk);
        while (pending_items.size() > 0 || in_valid || expected_results.size() > 0);
    endtask

    function automatic ept_pkg::t_in mk(input logic [1:0] k, input logic [3:0] h,
                                        input logic [15:0] id, input logic [15:0] sq,
                                        input logic [31:0] rtt, input logic rn);
        ept_pkg::t_in it;
        it.kind = k;
        it.host = h;
        it.echo_id = id;
        it.seq = sq;
        it.rtt_us = rtt;
        it.runt = rn;
        return it;
    endfunction

    // generator side copy of the sequence counter, for well-formed replies
    logic [15:0] gen_seq = '0;

    task automatic add(input ept_pkg::t_in it, input logic [4:0] hosts);
        if (it.kind == ept_pkg::KIND_SEND && it.host < hosts) gen_seq++;
        pending_items.push_back(it);
    endtask

    task automatic random_phase(input logic [15:0] ident, input logic [4:0] hosts,
                                input int count, input bit with_hold);
        ept_pkg::t_in it;
        int r;
        write_reg(ept_pkg::CFG_OUR_IDENT, ident);
        write_reg(ept_pkg::CFG_HOSTS_IN_USE, 16'(hosts));
        for (int n = 0; n < count; n++) begin
            it.host = (hosts == 0 || $urandom_range(0, 9) == 0) ?
                      4'($urandom_range(0, 15)) : 4'($urandom_range(0, hosts - 1));
            it.echo_id = ($urandom_range(0, 19) == 0) ? 16'($urandom) : ident;
            it.runt = ($urandom_range(0, 19) == 0);
            it.rtt_us = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 5000);
            it.seq = ($urandom_range(0, 9) == 0) ? 16'($urandom) :
                     gen_seq - 16'($urandom_range(1, 30));
            r = $urandom_range(0, 99);
            it.kind = (r < 35) ? ept_pkg::KIND_SEND : (r < 77) ? ept_pkg::KIND_REPLY :
                      (r < 87) ? ept_pkg::KIND_ERROR : ept_pkg::KIND_CLOSE;
            add(it, hosts);
        end
        if (with_hold) begin
            do @(negedge i_clk); while (pending_items.size() > count - 20);
            hold_reqs++;
        end
        drain();
    endtask

    initial begin
        for (int i = 0; i < 16; i++) begin
            sent_tot[i] = '0; recv_tot[i] = '0; dup_tot[i] = '0;
            p_sent[i] = '0; p_recv[i] = '0; p_dup[i] = '0; p_trip[i] = '0; p_err[i] = 0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: all hosts, all-ones identifier
        write_reg(ept_pkg::CFG_OUR_IDENT, 16'hFFFF);
        write_reg(ept_pkg::CFG_HOSTS_IN_USE, 16'd16);
        add(mk(ept_pkg::KIND_CLOSE, 4'd0, '0, '0, '0, 1'b0), 5'd16);
        add(mk(ept_pkg::KIND_SEND, 4'd0, '0, '0, '0, 1'b0), 5'd16);
        add(mk(ept_pkg::KIND_SEND, 4'd15, '0, '0, '0, 1'b0), 5'd16);
        add(mk(ept_pkg::KIND_REPLY, 4'd0, 16'hFFFF, 16'd0, 32'hFFFF_FFFF, 1'b0), 5'd16);
        add(mk(ept_pkg::KIND_REPLY, 4'd0, 16'hFFFF, 16'd0, 32'd1, 1'b0), 5'd16);
        add(mk(ept_pkg::KIND_REPLY, 4'd15, 16'hFFFF, 16'd1, 32'd7, 1'b1), 5'd16);
        add(mk(ept_pkg::KIND_REPLY, 4'd15, 16'h0000, 16'd1, 32'd7, 1'b0), 5'd16);
        add(mk(ept_pkg::KIND_ERROR, 4'd15, 16'hFFFF, '0, '0, 1'b1), 5'd16);
        add(mk(ept_pkg::KIND_ERROR, 4'd15, 16'hFFFF, '0, '0, 1'b0), 5'd16);
        add(mk(ept_pkg::KIND_ERROR, 4'd0, 16'h1234, '0, '0, 1'b0), 5'd16);
        add(mk(ept_pkg::KIND_CLOSE, 4'd15, '0, '0, '0, 1'b0), 5'd16);
        add(mk(ept_pkg::KIND_CLOSE, 4'd0, '0, '0, '0, 1'b0), 5'd16);
        add(mk(ept_pkg::KIND_SEND, 4'd3, '0, '0, '0, 1'b0), 5'd16);
        add(mk(ept_pkg::KIND_CLOSE, 4'd3, '0, '0, '0, 1'b0), 5'd16);
        add(mk(ept_pkg::KIND_REPLY, 4'd3, 16'hFFFF, 16'hFFFF, 32'd100, 1'b0), 5'd16);
        add(mk(ept_pkg::KIND_REPLY, 4'd3, 16'hFFFF, 16'd1023, 32'd300, 1'b0), 5'd16);
        add(mk(ept_pkg::KIND_CLOSE, 4'd3, '0, '0, '0, 1'b0), 5'd16);
        drain();
        // no host in use: everything is dropped
        write_reg(ept_pkg::CFG_HOSTS_IN_USE, 16'd0);
        add(mk(ept_pkg::KIND_SEND, 4'd0, '0, '0, '0, 1'b0), 5'd0);
        add(mk(ept_pkg::KIND_REPLY, 4'd0, 16'hFFFF, 16'd2, 32'd5, 1'b0), 5'd0);
        add(mk(ept_pkg::KIND_ERROR, 4'd0, 16'hFFFF, '0, '0, 1'b0), 5'd0);
        add(mk(ept_pkg::KIND_CLOSE, 4'd0, '0, '0, '0, 1'b0), 5'd0);
        drain();
        write_reg(ept_pkg::CFG_HOSTS_IN_USE, 16'd1);
        write_reg(ept_pkg::CFG_OUR_IDENT, 16'h0000);
        add(mk(ept_pkg::KIND_SEND, 4'd1, '0, '0, '0, 1'b0), 5'd1);
        add(mk(ept_pkg::KIND_SEND, 4'd0, '0, '0, '0, 1'b0), 5'd1);
        add(mk(ept_pkg::KIND_REPLY, 4'd0, 16'h0000, gen_seq - 16'd1, 32'd0, 1'b0), 5'd1);
        add(mk(ept_pkg::KIND_CLOSE, 4'd0, '0, '0, '0, 1'b0), 5'd1);
        drain();

        random_phase(16'h0000, 5'd16, 200, 1'b1);
        random_phase(16'($urandom), 5'd1, 150, 1'b0);
        random_phase(16'hFFFF, 5'($urandom_range(2, 15)), 200, 1'b0);
        random_phase(16'($urandom), 5'd16, 250, 1'b1);

        repeat (200) @(posedge i_clk);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #30ms;
        $display("TEST FAILED");
        $finish;
    end
endmodule
`default_nettype wire
